// ===== rtl/bus_packet_multicast_group_filter_macros.svh =====
`ifndef BUS_PACKET_MULTICAST_GROUP_FILTER_MACROS_SVH
`define BUS_PACKET_MULTICAST_GROUP_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BPMGF_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BPMGF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/bpmgf_pkg.sv =====
package bpmgf_pkg;

  localparam int TableEntriesDef = 8;
  localparam int EntryW = 24;

  typedef enum logic [1:0] {
    MsgStream  = 2'd0,
    MsgMcast   = 2'd1,
    MsgUnicast = 2'd2,
    MsgOther   = 2'd3
  } msg_type_e;

  typedef enum logic [1:0] {
    CfgOwnPort    = 2'd0,
    CfgModuleKind = 2'd1,
    CfgPersist    = 2'd2,
    CfgWildcard   = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] CodeAck         = 8'hF0;
  localparam logic [7:0] CodeError       = 8'hF1;
  localparam logic [7:0] CodeModType     = 8'hF2;
  localparam logic [7:0] CodeReqType     = 8'hF3;
  localparam logic [7:0] CodeGroupAdd    = 8'hF4;
  localparam logic [7:0] CodeGroupRem    = 8'hF5;
  localparam logic [7:0] CodeGroupGet    = 8'hF6;
  localparam logic [7:0] CodeGroupReturn = 8'hF7;
  localparam logic [7:0] CodeGroupsClear = 8'hF8;

  localparam logic [2:0] AckLen   = 3'd5;
  localparam logic [2:0] TypeLen  = 3'd3;
  localparam logic [2:0] ClearLen = 3'd2;
  localparam logic [7:0] MaxArgs  = 8'd4;
  localparam logic [7:0] ShortLen = 8'd3;
  localparam logic [7:0] FullLen  = 8'd4;
  localparam logic [2:0] MaxReply = 3'd5;

endpackage

// ===== rtl/bus_packet_multicast_group_filter.sv =====
// Multicast group filter and management responder for one bus module.
// Input channel: one word per packet header plus its first four data bytes,
// taken on in_valid_i high and in_stall_o low. Output channel: one word per
// input word, offered on out_valid_o and taken when out_stall_i is low.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i; the
// user must write it only while the block is idle, which the block does not enforce.
// The group table lives in a one-port synchronous memory with a registered
// read and a valid bit per entry. Multicast packets and group add or remove
// commands scan the table one entry per cycle, then register their result in
// StFinish; an entry read passes StGetRd before StFinish and every other
// packet goes straight to StFinish. A new word is taken at the earliest in the
// cycle after the result is registered, never while one is still in work.
// A finished result waits in the output register while the receiver stalls;
// the block then takes the next input word but holds its result until the
// output register is free.
// Reset empties the table by clearing all valid bits at once and loads the
// configuration defaults; no clearing pass is needed.
module bus_packet_multicast_group_filter #(
  parameter int TABLE_ENTRIES = bpmgf_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  msg_type_i,
  input  logic [7:0]  dest_port_i,
  input  logic [15:0] group_target_i,
  input  logic [15:0] sender_i,
  input  logic [7:0]  payload_len_i,
  input  logic [7:0]  command_i,
  input  logic [7:0]  arg_one_i,
  input  logic [7:0]  arg_two_i,
  input  logic [7:0]  arg_three_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accept_o,
  output logic        reply_valid_o,
  output logic        reply_broadcast_o,
  output logic [15:0] reply_dest_o,
  output logic [7:0]  reply_port_o,
  output logic [2:0]  reply_len_o,
  output logic [7:0]  reply_byte0_o,
  output logic [7:0]  reply_byte1_o,
  output logic [7:0]  reply_byte2_o,
  output logic [7:0]  reply_byte3_o,
  output logic [7:0]  reply_byte4_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_ENTRIES);
  localparam logic [7:0] NumEntries8 = 8'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StGetRd  = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] own_port_q, module_kind_q, wildcard_q;
  logic       persist_q;

  logic [1:0]  msg_type_q;
  logic [7:0]  dest_port_q, payload_len_q, command_q, arg_one_q, arg_two_q, arg_three_q;
  logic [15:0] group_target_q, sender_q;

  logic [bpmgf_pkg::EntryW-1:0] tbl_mem [TABLE_ENTRIES];
  logic [bpmgf_pkg::EntryW-1:0] rdata_q;
  logic [TABLE_ENTRIES-1:0]     tbl_vld_q, tbl_vld_d;
  logic                         mem_re, mem_we;
  logic [IdxW-1:0]              mem_raddr;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_pend_q, rd_pend_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            hit_q, hit_d, found_q, found_d, free_q, free_d;
  logic [IdxW-1:0] found_idx_q, found_idx_d, free_idx_q, free_idx_d;

  logic        in_go, in_own, in_len_ok, fin_go, out_free;
  logic        own_hit, uni_own, len_ok, err;
  logic [7:0]  filt;
  logic [bpmgf_pkg::EntryW-1:0] key, ent;
  logic [2:0]  err_n;

  logic        r_accept, r_reply, r_bcast;
  logic [15:0] r_dest;
  logic [7:0]  r_port, r_b0, r_b1, r_b2, r_b3, r_b4;
  logic [2:0]  r_len;

  logic        out_valid_q, out_valid_d;
  logic        accept_q, reply_valid_q, reply_bcast_q;
  logic [15:0] reply_dest_q;
  logic [7:0]  reply_port_q, b0_q, b1_q, b2_q, b3_q, b4_q;
  logic [2:0]  reply_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_port_q    <= '0;
      module_kind_q <= '0;
      persist_q     <= 1'b0;
      wildcard_q    <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (bpmgf_pkg::cfg_idx_e'(cfg_index_i))
        bpmgf_pkg::CfgOwnPort:    own_port_q    <= cfg_data_i;
        bpmgf_pkg::CfgModuleKind: module_kind_q <= cfg_data_i;
        bpmgf_pkg::CfgPersist:    persist_q     <= cfg_data_i[0];
        bpmgf_pkg::CfgWildcard:   wildcard_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_go      = in_valid_i && (state_q == StIdle);
  assign in_own     = (dest_port_i == own_port_q);
  assign in_len_ok  = (payload_len_i == bpmgf_pkg::ShortLen) ||
                      (payload_len_i == bpmgf_pkg::FullLen);

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      msg_type_q     <= msg_type_i;
      dest_port_q    <= dest_port_i;
      group_target_q <= group_target_i;
      sender_q       <= sender_i;
      payload_len_q  <= payload_len_i;
      command_q      <= command_i;
      arg_one_q      <= arg_one_i;
      arg_two_q      <= arg_two_i;
      arg_three_q    <= arg_three_i;
    end
  end

  assign own_hit = (dest_port_q == own_port_q);
  assign uni_own = (msg_type_q == bpmgf_pkg::MsgUnicast) && own_hit;
  assign len_ok  = (payload_len_q == bpmgf_pkg::ShortLen) ||
                   (payload_len_q == bpmgf_pkg::FullLen);
  assign filt    = (payload_len_q == bpmgf_pkg::FullLen) ? arg_three_q : wildcard_q;
  assign key     = {arg_one_q, arg_two_q, filt};
  assign ent     = tbl_vld_q[rd_idx_q] ? rdata_q : '0;

  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_go   = (state_q == StFinish) && out_free;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cnt_q[IdxW-1:0];
    if (state_q == StScan && cnt_q != LastCnt) begin
      mem_re = 1'b1;
    end else if (state_q == StGetRd) begin
      mem_re    = 1'b1;
      mem_raddr = arg_one_q[IdxW-1:0];
    end
  end

  assign mem_we = fin_go && uni_own && (command_q == bpmgf_pkg::CodeGroupAdd) &&
                  len_ok && !found_q && free_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[free_idx_q] <= key;
    end
    if (mem_re) begin
      rdata_q <= tbl_mem[mem_raddr];
    end
  end

  always_comb begin
    tbl_vld_d = tbl_vld_q;
    if (mem_we) begin
      tbl_vld_d[free_idx_q] = 1'b1;
    end
    if (fin_go && uni_own && len_ok && found_q &&
        command_q == bpmgf_pkg::CodeGroupRem) begin
      tbl_vld_d[found_idx_q] = 1'b0;
    end
    if (fin_go && uni_own && command_q == bpmgf_pkg::CodeGroupsClear) begin
      tbl_vld_d = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    found_d     = found_q;
    free_d      = free_q;
    found_idx_d = found_idx_q;
    free_idx_d  = free_idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_go) begin
          cnt_d   = '0;
          hit_d   = 1'b0;
          found_d = 1'b0;
          free_d  = 1'b0;
          if (msg_type_i == bpmgf_pkg::MsgMcast) begin
            state_d = StScan;
          end else if (msg_type_i == bpmgf_pkg::MsgUnicast && in_own && in_len_ok &&
                       (command_i == bpmgf_pkg::CodeGroupAdd ||
                        command_i == bpmgf_pkg::CodeGroupRem)) begin
            state_d = StScan;
          end else if (msg_type_i == bpmgf_pkg::MsgUnicast && in_own &&
                       command_i == bpmgf_pkg::CodeGroupGet && arg_one_i < NumEntries8) begin
            state_d = StGetRd;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        if (rd_pend_q) begin
          if (ent != '0) begin
            if (ent[23:8] == group_target_q &&
                (ent[7:0] == command_q || ent[7:0] == wildcard_q)) begin
              hit_d = 1'b1;
            end
            if (ent == key && !found_q) begin
              found_d     = 1'b1;
              found_idx_d = rd_idx_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if (cnt_q != LastCnt) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = cnt_q[IdxW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else if (!rd_pend_q) begin
          state_d = StFinish;
        end
      end
      StGetRd: begin
        rd_idx_d = arg_one_q[IdxW-1:0];
        state_d  = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tbl_vld_q   <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      tbl_vld_q   <= tbl_vld_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      rd_idx_q    <= rd_idx_d;
      hit_q       <= hit_d;
      found_q     <= found_d;
      free_q      <= free_d;
      found_idx_q <= found_idx_d;
      free_idx_q  <= free_idx_d;
    end
  end

  assign err_n = (payload_len_q > bpmgf_pkg::MaxArgs) ? 3'd4 : payload_len_q[2:0];

  always_comb begin
    r_accept = 1'b0;
    r_reply  = 1'b0;
    r_bcast  = 1'b0;
    r_dest   = '0;
    r_port   = '0;
    r_len    = '0;
    r_b0     = '0;
    r_b1     = '0;
    r_b2     = '0;
    r_b3     = '0;
    r_b4     = '0;
    err      = 1'b0;
    case (msg_type_q)
      bpmgf_pkg::MsgStream: r_accept = own_hit;
      bpmgf_pkg::MsgMcast:  r_accept = hit_q;
      bpmgf_pkg::MsgUnicast: begin
        if (own_hit) begin
          unique case (command_q) inside
            bpmgf_pkg::CodeReqType: begin
              r_reply = 1'b1;
              r_bcast = 1'b1;
              r_port  = own_port_q;
              r_len   = bpmgf_pkg::TypeLen;
              r_b0    = bpmgf_pkg::CodeModType;
              r_b1    = module_kind_q;
              r_b2    = {7'd0, persist_q};
            end
            bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::CodeGroupRem: begin
              if (len_ok && (command_q == bpmgf_pkg::CodeGroupRem || found_q || free_q)) begin
                r_reply = 1'b1;
                r_bcast = 1'b1;
                r_dest  = sender_q;
                r_len   = bpmgf_pkg::AckLen;
                r_b0    = bpmgf_pkg::CodeAck;
                r_b1    = command_q;
                r_b2    = arg_one_q;
                r_b3    = arg_two_q;
                r_b4    = filt;
              end else begin
                err = 1'b1;
              end
            end
            bpmgf_pkg::CodeGroupGet: begin
              if (arg_one_q < NumEntries8) begin
                r_reply = 1'b1;
                r_bcast = 1'b1;
                r_dest  = sender_q;
                r_len   = bpmgf_pkg::AckLen;
                r_b0    = bpmgf_pkg::CodeGroupReturn;
                r_b1    = arg_one_q;
                r_b2    = ent[23:16];
                r_b3    = ent[15:8];
                r_b4    = ent[7:0];
              end else begin
                err = 1'b1;
              end
            end
            bpmgf_pkg::CodeGroupsClear: begin
              r_reply = 1'b1;
              r_bcast = 1'b1;
              r_dest  = sender_q;
              r_len   = bpmgf_pkg::ClearLen;
              r_b0    = bpmgf_pkg::CodeAck;
              r_b1    = bpmgf_pkg::CodeGroupsClear;
            end
            default: r_accept = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    if (err) begin
      r_reply = 1'b1;
      r_dest  = sender_q;
      r_len   = err_n + 3'd1;
      r_b0    = bpmgf_pkg::CodeError;
      r_b1    = (err_n >= 3'd1) ? command_q : 8'd0;
      r_b2    = (err_n >= 3'd2) ? arg_one_q : 8'd0;
      r_b3    = (err_n >= 3'd3) ? arg_two_q : 8'd0;
      r_b4    = (err_n >= 3'd4) ? arg_three_q : 8'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      accept_q      <= r_accept;
      reply_valid_q <= r_reply;
      reply_bcast_q <= r_bcast;
      reply_dest_q  <= r_dest;
      reply_port_q  <= r_port;
      reply_len_q   <= r_len;
      b0_q          <= r_b0;
      b1_q          <= r_b1;
      b2_q          <= r_b2;
      b3_q          <= r_b3;
      b4_q          <= r_b4;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accept_o          = accept_q;
  assign reply_valid_o     = reply_valid_q;
  assign reply_broadcast_o = reply_bcast_q;
  assign reply_dest_o      = reply_dest_q;
  assign reply_port_o      = reply_port_q;
  assign reply_len_o       = reply_len_q;
  assign reply_byte0_o     = b0_q;
  assign reply_byte1_o     = b1_q;
  assign reply_byte2_o     = b2_q;
  assign reply_byte3_o     = b3_q;
  assign reply_byte4_o     = b4_q;

endmodule

// ===== rtl/bpmgf_assert.sv =====
`include "bus_packet_multicast_group_filter_macros.svh"

module bpmgf_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accept_o,
  input logic        reply_valid_o,
  input logic        reply_broadcast_o,
  input logic [15:0] reply_dest_o,
  input logic [7:0]  reply_port_o,
  input logic [2:0]  reply_len_o,
  input logic [7:0]  reply_byte0_o
);

  `BPMGF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(reply_len_o) && $stable(reply_byte0_o) && $stable(accept_o),
    "Stalled output word changed")

  `BPMGF_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o,
    "Input taken again while an item is in work")

  `BPMGF_ASSERT_NOW(a_no_reply_zero, out_valid_o && !reply_valid_o,
    reply_len_o == 3'd0 && reply_dest_o == 16'd0 && reply_port_o == 8'd0 &&
    !reply_broadcast_o && reply_byte0_o == 8'd0,
    "Reply fields set without a reply")

  `BPMGF_ASSERT_NOW(a_accept_or_reply, out_valid_o, !(accept_o && reply_valid_o),
    "Packet both accepted and answered")

  `BPMGF_ASSERT_NOW(a_reply_len, out_valid_o && reply_valid_o,
    reply_len_o != 3'd0 && reply_len_o <= bpmgf_pkg::MaxReply,
    "Reply length out of range")

endmodule

bind bus_packet_multicast_group_filter bpmgf_assert u_bpmgf_assert (.*);

// ===== tb/bus_packet_multicast_group_filter_tb.sv =====
`timescale 1ns / 1ps

module bus_packet_multicast_group_filter_tb;

  localparam int Entries = bpmgf_pkg::TableEntriesDef;
  localparam int SettleCycles = Entries + 4;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    bpmgf_pkg::msg_type_e kind;
    logic [7:0]  dest_port;
    logic [15:0] group_target;
    logic [15:0] sender;
    logic [7:0]  payload_len;
    logic [7:0]  command;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
    logic [7:0]  arg_three;
  } packet_t;

  typedef struct packed {
    logic            accept;
    logic            valid;
    logic            broadcast;
    logic [15:0]     dest;
    logic [7:0]      port;
    logic [2:0]      len;
    logic [4:0][7:0] data;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  msg_type_i = '0;
  logic [7:0]  dest_port_i = '0;
  logic [15:0] group_target_i = '0;
  logic [15:0] sender_i = '0;
  logic [7:0]  payload_len_i = '0;
  logic [7:0]  command_i = '0;
  logic [7:0]  arg_one_i = '0;
  logic [7:0]  arg_two_i = '0;
  logic [7:0]  arg_three_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accept_o;
  logic        reply_valid_o;
  logic        reply_broadcast_o;
  logic [15:0] reply_dest_o;
  logic [7:0]  reply_port_o;
  logic [2:0]  reply_len_o;
  logic [7:0]  reply_byte0_o;
  logic [7:0]  reply_byte1_o;
  logic [7:0]  reply_byte2_o;
  logic [7:0]  reply_byte3_o;
  logic [7:0]  reply_byte4_o;

  logic [23:0] group_mem [Entries] = '{default: '0};
  logic [7:0]  port_cfg = 8'h00;
  logic [7:0]  kind_cfg = 8'h00;
  logic        persist_cfg = 1'b0;
  logic [7:0]  wildcard_cfg = 8'hFF;

  verdict_t pending_verdicts [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;

  bus_packet_multicast_group_filter #(
    .TABLE_ENTRIES(Entries)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .msg_type_i       (msg_type_i),
    .dest_port_i      (dest_port_i),
    .group_target_i   (group_target_i),
    .sender_i         (sender_i),
    .payload_len_i    (payload_len_i),
    .command_i        (command_i),
    .arg_one_i        (arg_one_i),
    .arg_two_i        (arg_two_i),
    .arg_three_i      (arg_three_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accept_o         (accept_o),
    .reply_valid_o    (reply_valid_o),
    .reply_broadcast_o(reply_broadcast_o),
    .reply_dest_o     (reply_dest_o),
    .reply_port_o     (reply_port_o),
    .reply_len_o      (reply_len_o),
    .reply_byte0_o    (reply_byte0_o),
    .reply_byte1_o    (reply_byte1_o),
    .reply_byte2_o    (reply_byte2_o),
    .reply_byte3_o    (reply_byte3_o),
    .reply_byte4_o    (reply_byte4_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** bus_packet_multicast_group_filter: FAILED **");
      $finish;
    end
  end

  function automatic verdict_t reply_word(input logic bcast, input logic [15:0] dest,
                                          input logic [7:0] port, input logic [2:0] len,
                                          input logic [4:0][7:0] bytes);
    verdict_t v;
    int i;
    v = '0;
    v.valid = 1'b1;
    v.broadcast = bcast;
    v.dest = dest;
    v.port = port;
    v.len = len;
    for (i = 0; i < 5; i++) begin
      if (i < int'(len)) v.data[i] = bytes[i];
    end
    return v;
  endfunction

  function automatic verdict_t error_word(input packet_t p);
    logic [2:0] n;
    n = (p.payload_len > bpmgf_pkg::MaxArgs) ? bpmgf_pkg::MaxArgs[2:0] : p.payload_len[2:0];
    return reply_word(1'b0, p.sender, 8'h00, n + 3'd1,
                      {p.arg_three, p.arg_two, p.arg_one, p.command, bpmgf_pkg::CodeError});
  endfunction

  function automatic verdict_t filter_packet(input packet_t p);
    verdict_t    v;
    logic [7:0]  filt;
    logic [23:0] key;
    logic [23:0] entry;
    logic        stored;
    int          found;
    int          i;
    v = '0;
    case (p.kind)
      bpmgf_pkg::MsgStream: v.accept = (p.dest_port == port_cfg);
      bpmgf_pkg::MsgMcast: begin
        for (i = 0; i < Entries; i++) begin
          if (group_mem[i] != '0 && group_mem[i][23:8] == p.group_target &&
              (group_mem[i][7:0] == p.command || group_mem[i][7:0] == wildcard_cfg))
            v.accept = 1'b1;
        end
      end
      bpmgf_pkg::MsgUnicast: begin
        if (p.dest_port == port_cfg) begin
          case (p.command) inside
            bpmgf_pkg::CodeReqType: begin
              v = reply_word(1'b1, 16'h0000, port_cfg, bpmgf_pkg::TypeLen,
                             {8'h00, 8'h00, 7'h00, persist_cfg, kind_cfg,
                              bpmgf_pkg::CodeModType});
            end
            bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::CodeGroupRem: begin
              if (p.payload_len != bpmgf_pkg::ShortLen &&
                  p.payload_len != bpmgf_pkg::FullLen) begin
                v = error_word(p);
              end else begin
                filt = (p.payload_len == bpmgf_pkg::FullLen) ? p.arg_three : wildcard_cfg;
                key = {p.arg_one, p.arg_two, filt};
                found = -1;
                for (i = 0; i < Entries; i++) begin
                  if (found < 0 && group_mem[i] != '0 && group_mem[i] == key) found = i;
                end
                stored = 1'b1;
                if (p.command == bpmgf_pkg::CodeGroupAdd) begin
                  if (found < 0) begin
                    stored = 1'b0;
                    for (i = 0; i < Entries; i++) begin
                      if (!stored && group_mem[i] == '0) begin
                        group_mem[i] = key;
                        stored = 1'b1;
                      end
                    end
                  end
                end else if (found >= 0) begin
                  group_mem[found] = '0;
                end
                if (stored) begin
                  v = reply_word(1'b1, p.sender, 8'h00, bpmgf_pkg::AckLen,
                                 {filt, p.arg_two, p.arg_one, p.command, bpmgf_pkg::CodeAck});
                end else begin
                  v = error_word(p);
                end
              end
            end
            bpmgf_pkg::CodeGroupGet: begin
              if (int'(p.arg_one) < Entries) begin
                entry = group_mem[int'(p.arg_one)];
                v = reply_word(1'b1, p.sender, 8'h00, bpmgf_pkg::AckLen,
                               {entry[7:0], entry[15:8], entry[23:16], p.arg_one,
                                bpmgf_pkg::CodeGroupReturn});
              end else begin
                v = error_word(p);
              end
            end
            bpmgf_pkg::CodeGroupsClear: begin
              for (i = 0; i < Entries; i++) group_mem[i] = '0;
              v = reply_word(1'b1, p.sender, 8'h00, bpmgf_pkg::ClearLen,
                             {24'h000000, bpmgf_pkg::CodeGroupsClear, bpmgf_pkg::CodeAck});
            end
            default: v.accept = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with no packet pending");
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("accept", 16'(want.accept), 16'(accept_o));
        check_field("reply_valid", 16'(want.valid), 16'(reply_valid_o));
        check_field("reply_broadcast", 16'(want.broadcast), 16'(reply_broadcast_o));
        check_field("reply_dest", want.dest, reply_dest_o);
        check_field("reply_port", 16'(want.port), 16'(reply_port_o));
        check_field("reply_len", 16'(want.len), 16'(reply_len_o));
        check_field("reply_byte0", 16'(want.data[0]), 16'(reply_byte0_o));
        check_field("reply_byte1", 16'(want.data[1]), 16'(reply_byte1_o));
        check_field("reply_byte2", 16'(want.data[2]), 16'(reply_byte2_o));
        check_field("reply_byte3", 16'(want.data[3]), 16'(reply_byte3_o));
        check_field("reply_byte4", 16'(want.data[4]), 16'(reply_byte4_o));
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows
  // acceptance, with valid still high so that the next word can follow without a gap.
  task automatic send_packet(input packet_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    msg_type_i <= p.kind;
    dest_port_i <= p.dest_port;
    group_target_i <= p.group_target;
    sender_i <= p.sender;
    payload_len_i <= p.payload_len;
    command_i <= p.command;
    arg_one_i <= p.arg_one;
    arg_two_i <= p.arg_two;
    arg_three_i <= p.arg_three;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_verdicts.push_back(filter_packet(p));
    @(negedge clk_i);
  endtask

  task automatic send_mgmt(input logic [7:0] cmd, input logic [7:0] len, input logic [7:0] a1,
                           input logic [7:0] a2, input logic [7:0] a3);
    send_packet('{bpmgf_pkg::MsgUnicast, port_cfg, 16'($urandom), 16'($urandom), len, cmd,
                  a1, a2, a3});
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] own, input logic [7:0] kind,
                            input logic persist, input logic [7:0] wild);
    logic [7:0] values [4];
    int i;
    values[bpmgf_pkg::CfgOwnPort] = own;
    values[bpmgf_pkg::CfgModuleKind] = kind;
    values[bpmgf_pkg::CfgPersist] = {7'h00, persist};
    values[bpmgf_pkg::CfgWildcard] = wild;
    for (i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i <= values[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    port_cfg = own;
    kind_cfg = kind;
    persist_cfg = persist;
    wildcard_cfg = wild;
  endtask

  function automatic logic [15:0] pool_group();
    return 16'(16'h2471 * $urandom_range(9));
  endfunction

  function automatic logic [7:0] pool_filter();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return wildcard_cfg;
      default: return 8'($urandom_range(3));
    endcase
  endfunction

  // A quarter of the words are pure noise; the rest are management commands, stream and
  // multicast words to this port from a small pool, so the table fills and matches.
  function automatic packet_t random_packet();
    packet_t     p;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [15:0] g;
    int          sel;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    p.kind = bpmgf_pkg::msg_type_e'(r2[17:16]);
    p.dest_port = r0[7:0];
    p.payload_len = r0[15:8];
    p.command = r0[23:16];
    p.arg_one = r0[31:24];
    p.group_target = r1[15:0];
    p.sender = r1[31:16];
    p.arg_two = r2[7:0];
    p.arg_three = r2[15:8];
    sel = $urandom_range(99);
    if (sel >= 25) begin
      p.kind = bpmgf_pkg::MsgUnicast;
      p.dest_port = port_cfg;
      if ($urandom_range(9) != 0) p.payload_len = 8'($urandom_range(4, 3));
      g = pool_group();
      p.arg_one = g[15:8];
      p.arg_two = g[7:0];
      p.arg_three = pool_filter();
      if (sel < 55) begin
        p.command = bpmgf_pkg::CodeGroupAdd;
      end else if (sel < 70) begin
        p.command = bpmgf_pkg::CodeGroupRem;
      end else if (sel < 78) begin
        p.command = bpmgf_pkg::CodeGroupGet;
        p.arg_one = 8'($urandom_range(Entries + 1));
      end else if (sel < 80) begin
        p.command = bpmgf_pkg::CodeGroupsClear;
      end else if (sel < 83) begin
        p.command = bpmgf_pkg::CodeReqType;
      end else if (sel < 97) begin
        p.kind = bpmgf_pkg::MsgMcast;
        p.group_target = pool_group();
        p.command = pool_filter();
      end else begin
        p.kind = bpmgf_pkg::MsgStream;
      end
    end
    return p;
  endfunction

  task automatic test_basic_packets();
    send_packet('{bpmgf_pkg::MsgStream, 8'h00, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF});
    send_packet('{bpmgf_pkg::MsgStream, 8'hFF, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00});
    send_packet('{bpmgf_pkg::MsgOther, 8'h00, 16'hFFFF, 16'hFFFF, 8'h04,
                  bpmgf_pkg::CodeReqType, 8'h00, 8'h00, 8'h00});
    send_packet('{bpmgf_pkg::MsgUnicast, 8'h01, 16'h0000, 16'h1234, 8'h01,
                  bpmgf_pkg::CodeReqType, 8'h00, 8'h00, 8'h00});
    send_mgmt(bpmgf_pkg::CodeReqType, 8'h01, 8'h00, 8'h00, 8'h00);
    send_mgmt(8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_group_management();
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'hFF, 8'hFF, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'hFF, 8'hFF, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::ShortLen, 8'h00, 8'h00, 8'h3C);
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'h00, 8'h00, 8'h00);
    send_packet('{bpmgf_pkg::MsgMcast, 8'h00, 16'hFFFF, 16'h0001, 8'h04, 8'h00, 8'h00,
                  8'h00, 8'h00});
    send_packet('{bpmgf_pkg::MsgMcast, 8'h00, 16'h0000, 16'h0002, 8'h04, 8'h5A, 8'h00,
                  8'h00, 8'h00});
    send_mgmt(bpmgf_pkg::CodeGroupGet, 8'h02, 8'h00, 8'h00, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupGet, 8'h02, 8'h08, 8'h00, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupRem, bpmgf_pkg::FullLen, 8'hFF, 8'hFF, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupRem, bpmgf_pkg::ShortLen, 8'h12, 8'h34, 8'h00);
    send_mgmt(bpmgf_pkg::CodeGroupAdd, 8'h02, 8'h12, 8'h34, 8'h56);
    send_mgmt(bpmgf_pkg::CodeGroupRem, 8'hFF, 8'h12, 8'h34, 8'h56);
    send_mgmt(bpmgf_pkg::CodeGroupsClear, 8'h01, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_table_full();
    int i;
    for (i = 0; i < Entries; i++) begin
      send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'(i + 1), 8'h5A, 8'(i));
    end
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'hA0, 8'h5A, 8'h01);
    send_mgmt(bpmgf_pkg::CodeGroupAdd, bpmgf_pkg::FullLen, 8'h01, 8'h5A, 8'h00);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count,
                                     input logic [7:0] own, input logic [7:0] kind,
                                     input logic persist, input logic [7:0] wild);
    settle_block();
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    set_config(own, kind, persist, wild);
    repeat (count) send_packet(random_packet());
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_packets();
    test_group_management();
    test_table_full();
    test_random_traffic(0, 0, 210, 8'hFF, 8'hFF, 1'b1, 8'h00);
    test_random_traffic(76, 0, 210, 8'($urandom), 8'($urandom), 1'b0, 8'hFF);
    test_random_traffic(0, 76, 210, 8'h00, 8'h00, 1'b1, 8'($urandom));
    test_random_traffic(11, 11, 210, 8'($urandom), 8'h5A, 1'b0, bpmgf_pkg::CodeGroupAdd);
    settle_block();
    if (error_count == 0) begin
      $display("** bus_packet_multicast_group_filter: PASSED **");
    end else begin
      $display("** bus_packet_multicast_group_filter: FAILED **");
    end
    $finish;
  end

endmodule
